[hw/rtl/stdet_pkg.sv]
// ----------------------------------------------------------------------------
// stdet_pkg: shared types and constants of the shake and tilt detector
// Register indexes, register reset values, speed limit for "wheel still" and
// the status bundle passed from shake tracking to tilt debounce.
// ----------------------------------------------------------------------------
package stdet_pkg;

  // configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHAKE_WINDOW    = 3'd0,
    CFG_SHAKE_COUNT_MIN = 3'd1,
    CFG_SHAKE_HOLD      = 3'd2,
    CFG_TILT_SETTLE     = 3'd3,
    CFG_TILT_DEBOUNCE   = 3'd4,
    CFG_LIFT_THRESHOLD  = 3'd5
  } cfg_idx_t;

  // register reset values
  localparam logic [15:0] SHAKE_WINDOW_RST    = 16'd500;
  localparam logic [7:0]  SHAKE_COUNT_MIN_RST = 8'd10;
  localparam logic [15:0] SHAKE_HOLD_RST      = 16'd1000;
  localparam logic [15:0] TILT_SETTLE_RST     = 16'd1000;
  localparam logic [7:0]  TILT_DEBOUNCE_RST   = 8'd20;
  localparam logic [7:0]  LIFT_THRESHOLD_RST  = 8'd100;

  // committed orientation after reset (zl set)
  localparam logic [7:0] TILT_CODE_RST = 8'h80;

  // a wheel is still when |speed| < 1 rpm (16 units of 1/16 rpm)
  localparam logic signed [15:0] STILL_LIMIT = 16'sd16;

  // shake tracking result for the current beat
  typedef struct packed {
    logic shaking;    // shake flag after this beat
    logic sample_en;  // orientation may be sampled this beat
  } shake_status_t;

endpackage

[hw/rtl/stdet_shake.sv]
// ----------------------------------------------------------------------------
// stdet_shake: wake-event counting and shake flag hold/settle timing
// Counts still-wheel wake events in a window opened by the first such event,
// raises the shake flag, holds it, and gates orientation sampling.
// ----------------------------------------------------------------------------
module stdet_shake
  import stdet_pkg::*;
#(
  parameter int unsigned TS_W = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic [TS_W-1:0] now_ts,
  input  logic            wake_still,
  input  logic [15:0]     shake_window,
  input  logic [7:0]      shake_count_min,
  input  logic [15:0]     shake_hold,
  input  logic [15:0]     tilt_settle,
  output shake_status_t   status
);

  localparam int unsigned CMP_W = TS_W + 16;

  logic            awaiting_r, awaiting_nxt;
  logic [TS_W-1:0] window_start_r, window_start_nxt;
  logic [15:0]     wake_count_r, wake_count_nxt;
  logic            shake_flag_r, shake_flag_nxt;
  logic [TS_W-1:0] shake_start_r, shake_start_nxt;
  logic [TS_W-1:0] settle_start_r, settle_start_nxt;

  logic            first_wake;
  logic [15:0]     wake_count_inc;
  logic [15:0]     wake_count_upd;
  logic [TS_W-1:0] win_diff, hold_diff, settle_diff;
  logic            win_gt, hold_gt, settle_gt;
  logic            win_fire, hold_fire, sample_en;

  // elapsed times against the stored starts, all in parallel
  assign win_diff    = now_ts - window_start_r;
  assign hold_diff   = now_ts - shake_start_r;
  assign settle_diff = now_ts - settle_start_r;
  assign win_gt      = CMP_W'(win_diff) > CMP_W'(shake_window);
  assign hold_gt     = CMP_W'(hold_diff) > CMP_W'(shake_hold);
  assign settle_gt   = CMP_W'(settle_diff) > CMP_W'(tilt_settle);

  // count wake events, saturating; the first one opens the window
  assign first_wake     = wake_still & awaiting_r;
  assign wake_count_inc = (wake_count_r != 16'hFFFF) ? wake_count_r + 16'd1 : wake_count_r;
  always_comb begin
    if (!wake_still) begin
      wake_count_upd = wake_count_r;
    end else if (awaiting_r) begin
      wake_count_upd = 16'd1;
    end else begin
      wake_count_upd = wake_count_inc;
    end
  end

  // a window just opened has zero elapsed time, so it cannot judge yet;
  // a freshly set or freshly cleared flag likewise sees zero elapsed time
  assign win_fire  = ~first_wake & win_gt & (wake_count_upd > 16'(shake_count_min));
  assign hold_fire = ~win_fire & shake_flag_r & hold_gt;
  assign sample_en = ~shake_flag_nxt & ~hold_fire & settle_gt;

  always_comb begin
    awaiting_nxt     = awaiting_r & ~wake_still;
    window_start_nxt = first_wake ? now_ts : window_start_r;
    wake_count_nxt   = win_fire ? 16'd0 : wake_count_upd;
    shake_flag_nxt   = win_fire | (shake_flag_r & ~hold_fire);
    shake_start_nxt  = win_fire ? now_ts : shake_start_r;
    settle_start_nxt = hold_fire ? now_ts : settle_start_r;
  end

  assign status.shaking   = shake_flag_nxt;
  assign status.sample_en = sample_en;

  // update state once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r     <= 1'b1;
      window_start_r <= '0;
      wake_count_r   <= '0;
      shake_flag_r   <= 1'b0;
      shake_start_r  <= '0;
      settle_start_r <= '0;
    end else if (advance) begin
      awaiting_r     <= awaiting_nxt;
      window_start_r <= window_start_nxt;
      wake_count_r   <= wake_count_nxt;
      shake_flag_r   <= shake_flag_nxt;
      shake_start_r  <= shake_start_nxt;
      settle_start_r <= settle_start_nxt;
    end
  end

  // the window opens exactly once
  a_window_opens: assert property (@(posedge clk) disable iff (!rst_n)
    advance && first_wake |=> !awaiting_r && window_start_r == $past(now_ts))
    else $error("shake window did not open on first still wake event");

  // the flag only rises on a processed beat
  a_flag_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(shake_flag_r) |-> $past(advance) && wake_count_r == 16'd0)
    else $error("shake flag rose without a processed beat or count reset");

endmodule

[hw/rtl/stdet_tilt.sv]
// ----------------------------------------------------------------------------
// stdet_tilt: orientation remap and debounce
// Maps the six 6D bits to the tilt code and commits a new code after more
// than the debounce length of consecutive differing samples.
// ----------------------------------------------------------------------------
module stdet_tilt
  import stdet_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  shake_status_t status,
  input  logic [5:0]    orientation_bits,
  input  logic [7:0]    debounce_len,
  output logic [7:0]    tilt_nxt
);

  logic [7:0] committed_r;
  logic [7:0] debounce_r, debounce_nxt;
  logic [7:0] code;
  logic [7:0] count_upd;
  logic       commit;
  logic       update;

  // remap: zl bit7, zh bit6, xh bit5, xl bit4, yh bit3, yl bit2
  assign code = {orientation_bits[4], orientation_bits[5], orientation_bits[1],
                 orientation_bits[0], orientation_bits[3], orientation_bits[2], 2'b00};

  // count differing samples, saturating; drop the count on a match
  always_comb begin
    if (committed_r != code) begin
      count_upd = (debounce_r != 8'hFF) ? debounce_r + 8'd1 : debounce_r;
    end else begin
      count_upd = 8'd0;
    end
  end

  assign commit       = count_upd > debounce_len;
  assign debounce_nxt = commit ? 8'd0 : count_upd;
  assign update       = advance & status.sample_en;
  assign tilt_nxt     = (status.sample_en && commit) ? code : committed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      committed_r <= TILT_CODE_RST;
      debounce_r  <= '0;
    end else if (update) begin
      committed_r <= tilt_nxt;
      debounce_r  <= debounce_nxt;
    end
  end

  // the committed code only changes on a sampled beat
  a_commit_sampled: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(committed_r) |-> $past(update) && debounce_r == 8'd0)
    else $error("committed tilt changed outside a sampled beat");

endmodule

[hw/rtl/shake_and_tilt_detector.sv]
// ----------------------------------------------------------------------------
// shake_and_tilt_detector: motion status from wake events and 6D orientation
// Input register, single-pass shake/tilt update, result register.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_ready  | now_ms, wake_event, speeds, orient, prox
//  out      | out_valid / out_ready| tilt_code, shaking, lifted, motion_byte
//  cfg      | cfg_wr_en            | cfg_index, cfg_wdata
//
// One beat per cycle while the result side is not stalled; input register, then result register.
// Throughput is set by the single state update between input and result reg.
// Reset (rst_n low, synchronous) clears state and restores register defaults.
// A stalled result holds in the output register; the input register still
// takes one more beat, after which in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module shake_and_tilt_detector
  import stdet_pkg::*;
#(
  parameter int unsigned TIMESTAMP_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_now_ms,
  input  logic                  in_wake_event,
  input  logic signed [15:0]    in_left_speed,
  input  logic signed [15:0]    in_right_speed,
  input  logic [5:0]            in_orientation_bits,
  input  logic [7:0]            in_proximity,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_tilt_code,
  output logic                  out_shaking,
  output logic                  out_lifted,
  output logic [7:0]            out_motion_byte
);

  localparam int unsigned TS_W = TIMESTAMP_BITS;

  // configuration registers
  logic [15:0] shake_window_r;
  logic [7:0]  shake_count_min_r;
  logic [15:0] shake_hold_r;
  logic [15:0] tilt_settle_r;
  logic [7:0]  tilt_debounce_r;
  logic [7:0]  lift_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shake_window_r    <= SHAKE_WINDOW_RST;
      shake_count_min_r <= SHAKE_COUNT_MIN_RST;
      shake_hold_r      <= SHAKE_HOLD_RST;
      tilt_settle_r     <= TILT_SETTLE_RST;
      tilt_debounce_r   <= TILT_DEBOUNCE_RST;
      lift_threshold_r  <= LIFT_THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SHAKE_WINDOW:    shake_window_r    <= cfg_wdata;
        CFG_SHAKE_COUNT_MIN: shake_count_min_r <= cfg_wdata[7:0];
        CFG_SHAKE_HOLD:      shake_hold_r      <= cfg_wdata;
        CFG_TILT_SETTLE:     tilt_settle_r     <= cfg_wdata;
        CFG_TILT_DEBOUNCE:   tilt_debounce_r   <= cfg_wdata[7:0];
        CFG_LIFT_THRESHOLD:  lift_threshold_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              in_valid_r;
  logic [31:0]       now_ms_r;
  logic              wake_event_r;
  logic signed [15:0] left_speed_r;
  logic signed [15:0] right_speed_r;
  logic [5:0]        orientation_r;
  logic [7:0]        proximity_r;

  logic out_valid_r;
  logic advance;
  logic in_accept;

  assign advance   = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready  = ~in_valid_r | advance;
  assign in_accept = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      now_ms_r      <= in_now_ms;
      wake_event_r  <= in_wake_event;
      left_speed_r  <= in_left_speed;
      right_speed_r <= in_right_speed;
      orientation_r <= in_orientation_bits;
      proximity_r   <= in_proximity;
    end
  end

  // timestamp at the configured width (zero-extend or truncate)
  logic [TS_W+31:0] now_ext;
  logic [TS_W-1:0]  now_ts;
  assign now_ext = {{TS_W{1'b0}}, now_ms_r};
  assign now_ts  = now_ext[TS_W-1:0];

  // wake event with both wheels still
  logic wake_still;
  assign wake_still = wake_event_r
                    & (left_speed_r < STILL_LIMIT) & (left_speed_r > -STILL_LIMIT)
                    & (right_speed_r < STILL_LIMIT) & (right_speed_r > -STILL_LIMIT);

  shake_status_t status;
  logic [7:0]    tilt_nxt;
  logic          lifted;

  stdet_shake #(
    .TS_W (TS_W)
  ) u_shake (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (advance),
    .now_ts          (now_ts),
    .wake_still      (wake_still),
    .shake_window    (shake_window_r),
    .shake_count_min (shake_count_min_r),
    .shake_hold      (shake_hold_r),
    .tilt_settle     (tilt_settle_r),
    .status          (status)
  );

  stdet_tilt u_tilt (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (advance),
    .status           (status),
    .orientation_bits (orientation_r),
    .debounce_len     (tilt_debounce_r),
    .tilt_nxt         (tilt_nxt)
  );

  assign lifted = proximity_r > lift_threshold_r;

  // result register
  logic [7:0] tilt_code_r;
  logic       shaking_r;
  logic       lifted_r;
  logic [7:0] motion_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tilt_code_r   <= tilt_nxt;
      shaking_r     <= status.shaking;
      lifted_r      <= lifted;
      motion_byte_r <= tilt_nxt | {6'b0, lifted, status.shaking};
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tilt_code   = tilt_code_r;
  assign out_shaking     = shaking_r;
  assign out_lifted      = lifted_r;
  assign out_motion_byte = motion_byte_r;

  // a held input beat is never lost while the result side stalls
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r)
    else $error("input beat dropped before it was processed");

  // the summary byte always agrees with the separate result fields
  a_motion_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> motion_byte_r == (tilt_code_r | {6'b0, lifted_r, shaking_r}))
    else $error("motion byte disagrees with result fields");

endmodule

[verif/tb_shake_and_tilt_detector.sv]
// ----------------------------------------------------------------------------
// tb_shake_and_tilt_detector: self-checking bench for the shake/tilt detector
// A short directed table (reset values, field extremes, still-speed edges,
// lift threshold edges, shake onset and release, tilt debounce, timestamp
// wrap, ignored register indexes) is followed by random ticks under several
// register settings. Every beat runs through a behavioral model of the
// block; pinned rows give their own expected result, and each result beat is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_shake_and_tilt_detector;
  import stdet_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int IDLE_PCT       = 36;
  localparam int RESULT_LATENCY = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 7;
  localparam int PHASE_BEATS    = 240;

  // indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               wake_event;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [5:0]         orientation_bits;
    logic [7:0]         proximity;
  } tick_t;

  typedef struct packed {
    logic [7:0] tilt_code;
    logic       shaking;
    logic       lifted;
    logic [7:0] motion_byte;
  } motion_t;

  typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    tick_t                  tick;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    bit                     pinned;
    motion_t                want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [31:0]           in_now_ms;
  logic                  in_wake_event;
  logic signed [15:0]    in_left_speed;
  logic signed [15:0]    in_right_speed;
  logic [5:0]            in_orientation_bits;
  logic [7:0]            in_proximity;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_tilt_code;
  logic                  out_shaking;
  logic                  out_lifted;
  logic [7:0]            out_motion_byte;

  // typed expectation travels with the beat it belongs to
  logic    pinned_on;
  motion_t pinned_res;

  bit idle_on;
  bit stall_on;

  // model registers
  logic [15:0] win_ms, hold_ms, settle_ms;
  logic [7:0]  count_min, debounce_len, lift_thr;

  // model state
  bit          awaiting_wake;
  logic [31:0] window_start, shake_start, settle_start;
  logic [15:0] wake_count;
  bit          shake_on;
  logic [7:0]  committed_tilt, debounce_count;

  motion_t     pending_results[$];
  stim_row_t   directed_rows[$];
  int          beats_sent, results_checked, errors, quiet_cycles;
  int          shake_onsets, tilt_commits;
  logic [31:0] now_cursor;
  logic [5:0]  held_orient;

  shake_and_tilt_detector dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_now_ms           (in_now_ms),
    .in_wake_event       (in_wake_event),
    .in_left_speed       (in_left_speed),
    .in_right_speed      (in_right_speed),
    .in_orientation_bits (in_orientation_bits),
    .in_proximity        (in_proximity),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tilt_code       (out_tilt_code),
    .out_shaking         (out_shaking),
    .out_lifted          (out_lifted),
    .out_motion_byte     (out_motion_byte)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // ---------------------------------------------------------------------------
  // behavioral model
  // ---------------------------------------------------------------------------
  function automatic void clear_detector();
    win_ms         = SHAKE_WINDOW_RST;
    count_min      = SHAKE_COUNT_MIN_RST;
    hold_ms        = SHAKE_HOLD_RST;
    settle_ms      = TILT_SETTLE_RST;
    debounce_len   = TILT_DEBOUNCE_RST;
    lift_thr       = LIFT_THRESHOLD_RST;
    awaiting_wake  = 1'b1;
    window_start   = '0;
    wake_count     = '0;
    shake_on       = 1'b0;
    shake_start    = '0;
    settle_start   = '0;
    committed_tilt = TILT_CODE_RST;
    debounce_count = '0;
  endfunction

  function automatic void load_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    case (idx)
      CFG_SHAKE_WINDOW:    win_ms       = data;
      CFG_SHAKE_COUNT_MIN: count_min    = data[7:0];
      CFG_SHAKE_HOLD:      hold_ms      = data;
      CFG_TILT_SETTLE:     settle_ms    = data;
      CFG_TILT_DEBOUNCE:   debounce_len = data[7:0];
      CFG_LIFT_THRESHOLD:  lift_thr     = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic bit wheel_still(logic signed [15:0] s);
    return (s < STILL_LIMIT) && (s > -STILL_LIMIT);
  endfunction

  function automatic logic [31:0] ms_since(logic [31:0] now, logic [31:0] since);
    return now - since;
  endfunction

  // advance the model by one tick and return the status it reports
  function automatic motion_t update_motion(tick_t t);
    logic [7:0] code;
    logic       lift;
    motion_t    r;
    // count wake events only while both wheels stand still
    if (t.wake_event && wheel_still(t.left_speed) && wheel_still(t.right_speed)) begin
      if (awaiting_wake) begin
        window_start  = t.now_ms;
        awaiting_wake = 1'b0;
        wake_count    = '0;
      end
      if (wake_count != 16'hFFFF) wake_count++;
    end
    // judge the count once the window has passed
    if (ms_since(t.now_ms, window_start) > {16'b0, win_ms} &&
        wake_count > {8'b0, count_min}) begin
      if (!shake_on) shake_onsets++;
      shake_on    = 1'b1;
      wake_count  = '0;
      shake_start = t.now_ms;
    end
    // release the shake flag after the hold time
    if (shake_on && ms_since(t.now_ms, shake_start) > {16'b0, hold_ms}) begin
      shake_on     = 1'b0;
      settle_start = t.now_ms;
    end
    // debounce the orientation outside shaking and settle time
    if (!shake_on && ms_since(t.now_ms, settle_start) > {16'b0, settle_ms}) begin
      code = {t.orientation_bits[4], t.orientation_bits[5], t.orientation_bits[1],
              t.orientation_bits[0], t.orientation_bits[3], t.orientation_bits[2], 2'b00};
      if (committed_tilt != code) begin
        if (debounce_count != 8'hFF) debounce_count++;
      end else begin
        debounce_count = '0;
      end
      if (debounce_count > debounce_len) begin
        committed_tilt = code;
        debounce_count = '0;
        tilt_commits++;
      end
    end
    lift          = t.proximity > lift_thr;
    r.tilt_code   = committed_tilt;
    r.shaking     = shake_on;
    r.lifted      = lift;
    r.motion_byte = committed_tilt | {6'b0, lift, 1'b0} | {7'b0, shake_on};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: predict on input beats, check result beats
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    tick_t   t;
    motion_t predicted;
    motion_t want;
    if (!rst_n) begin
      clear_detector();
    end else begin
      if (cfg_wr_en) load_register(cfg_index, cfg_wdata);
      if (in_valid && in_ready) begin
        t = '{in_now_ms, in_wake_event, in_left_speed, in_right_speed,
              in_orientation_bits, in_proximity};
        predicted = update_motion(t);
        pending_results.push_back(pinned_on ? pinned_res : predicted);
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected, actual tilt %0h motion %0h",
                   $time, out_tilt_code, out_motion_byte);
        end else begin
          want = pending_results.pop_front();
          check_field("tilt_code", want.tilt_code, out_tilt_code);
          check_field("shaking", {7'b0, want.shaking}, {7'b0, out_shaking});
          check_field("lifted", {7'b0, want.lifted}, {7'b0, out_lifted});
          check_field("motion_byte", want.motion_byte, out_motion_byte);
        end
      end
    end
  end

  // stall the result side at random
  always @(posedge clk) begin
    out_ready <= !stall_on || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[shake_and_tilt_detector] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  task automatic send_tick(tick_t t, bit pin, motion_t want);
    // idle for a random number of cycles before the beat
    if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_now_ms           <= t.now_ms;
    in_wake_event       <= t.wake_event;
    in_left_speed       <= t.left_speed;
    in_right_speed      <= t.right_speed;
    in_orientation_bits <= t.orientation_bits;
    in_proximity        <= t.proximity;
    pinned_on           <= pin;
    pinned_res          <= want;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // hold off input until every result beat has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_checked != beats_sent) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [15:0] w, logic [15:0] c, logic [15:0] h,
                                logic [15:0] s, logic [15:0] d, logic [15:0] l);
    write_reg(CFG_SHAKE_WINDOW, w);
    write_reg(CFG_SHAKE_COUNT_MIN, c);
    write_reg(CFG_SHAKE_HOLD, h);
    write_reg(CFG_TILT_SETTLE, s);
    write_reg(CFG_TILT_DEBOUNCE, d);
    write_reg(CFG_LIFT_THRESHOLD, l);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus rows
  // ---------------------------------------------------------------------------
  function automatic stim_row_t tick_row(logic [31:0] now, logic wake, int ls, int rs,
                                         logic [5:0] ob, logic [7:0] prox);
    stim_row_t r;
    r.kind   = ROW_TICK;
    r.tick   = '{now, wake, ls[15:0], rs[15:0], ob, prox};
    r.idx    = '0;
    r.data   = '0;
    r.pinned = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic stim_row_t pin(stim_row_t r, logic [7:0] tilt, logic shake,
                                    logic lift, logic [7:0] motion);
    r.pinned = 1'b1;
    r.want   = '{tilt, shake, lift, motion};
    return r;
  endfunction

  function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    stim_row_t r;
    r = tick_row(0, 0, 0, 0, 0, 0);
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic void build_directed();
    // reset values, lift threshold edges, speed extremes and still edges
    directed_rows.push_back(pin(tick_row(0, 0, 0, 0, 6'h00, 0), 8'h80, 0, 0, 8'h80));
    directed_rows.push_back(pin(tick_row(1, 0, -32768, 32767, 6'h3F, 255),
                                8'h80, 0, 1, 8'h82));
    directed_rows.push_back(pin(tick_row(2, 0, 0, 0, 6'h00, 100), 8'h80, 0, 0, 8'h80));
    directed_rows.push_back(pin(tick_row(3, 0, 0, 0, 6'h00, 101), 8'h80, 0, 1, 8'h82));
    directed_rows.push_back(pin(tick_row(4, 1, 16, -32768, 6'h00, 0), 8'h80, 0, 0, 8'h80));
    directed_rows.push_back(pin(tick_row(5, 1, -16, 32767, 6'h00, 0), 8'h80, 0, 0, 8'h80));
    // first still wake opens the count window
    directed_rows.push_back(pin(tick_row(6, 1, 15, -15, 6'h00, 0), 8'h80, 0, 0, 8'h80));
    // short times and minimum counts
    directed_rows.push_back(write_row(CFG_SHAKE_WINDOW, 16'd0));
    directed_rows.push_back(write_row(CFG_SHAKE_COUNT_MIN, 16'd0));
    directed_rows.push_back(write_row(CFG_SHAKE_HOLD, 16'd3));
    directed_rows.push_back(write_row(CFG_TILT_SETTLE, 16'd2));
    directed_rows.push_back(write_row(CFG_TILT_DEBOUNCE, 16'd1));
    directed_rows.push_back(write_row(CFG_LIFT_THRESHOLD, 16'd0));
    directed_rows.push_back(write_row(CFG_SPARE_LO, 16'hFFFF));
    directed_rows.push_back(write_row(CFG_SPARE_HI, 16'hFFFF));
    // shake onset, retrigger, release, then debounce commit and reset
    directed_rows.push_back(tick_row(7, 0, 0, 0, 6'h00, 0));
    directed_rows.push_back(tick_row(9, 1, 3, -3, 6'h3F, 1));
    directed_rows.push_back(tick_row(13, 0, 0, 0, 6'h15, 0));
    directed_rows.push_back(tick_row(16, 0, 0, 0, 6'h15, 0));
    directed_rows.push_back(tick_row(17, 0, 0, 0, 6'h15, 1));
    directed_rows.push_back(tick_row(18, 0, 0, 0, 6'h2A, 0));
    directed_rows.push_back(tick_row(19, 0, 0, 0, 6'h15, 0));
    // timestamp wrap
    directed_rows.push_back(tick_row(32'hFFFF_FFFE, 1, 0, 0, 6'h2A, 255));
    directed_rows.push_back(tick_row(32'h0000_0001, 1, 0, 0, 6'h2A, 0));
  endfunction

  // mostly small time steps, runs of steady orientation, some noise
  function automatic tick_t next_random_tick();
    tick_t t;
    int    ls;
    int    rs;
    if ($urandom_range(0, 99) < 3) now_cursor = $urandom;
    else now_cursor = now_cursor + $urandom_range(0, 30);
    ls = ($urandom_range(0, 99) < 80) ? int'($urandom_range(0, 34)) - 17 : int'($urandom);
    rs = ($urandom_range(0, 99) < 80) ? int'($urandom_range(0, 34)) - 17 : int'($urandom);
    if ($urandom_range(0, 99) < 4) held_orient = 6'($urandom);
    t.now_ms           = now_cursor;
    t.wake_event       = $urandom_range(0, 99) < 40;
    t.left_speed       = ls[15:0];
    t.right_speed      = rs[15:0];
    t.orientation_bits = ($urandom_range(0, 99) < 10) ? 6'($urandom) : held_orient;
    t.proximity        = 8'($urandom);
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t row;
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_valid            = 1'b0;
    in_now_ms           = '0;
    in_wake_event       = 1'b0;
    in_left_speed       = '0;
    in_right_speed      = '0;
    in_orientation_bits = '0;
    in_proximity        = '0;
    pinned_on           = 1'b0;
    pinned_res          = '0;
    idle_on             = 1'b1;
    stall_on            = 1'b1;
    beats_sent          = 0;
    results_checked     = 0;
    errors              = 0;
    shake_onsets        = 0;
    tilt_commits        = 0;
    now_cursor          = 32'd100;
    held_orient         = 6'h20;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed table
    build_directed();
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) write_reg(row.idx, row.data);
      else send_tick(row.tick, row.pinned, row.want);
    end

    // random ticks under a series of register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings(0, 0, 0, 0, 0, 0);
        1: apply_settings(20, 2, 50, 30, 3, 0);
        2: apply_settings(16'(SHAKE_WINDOW_RST), 16'(SHAKE_COUNT_MIN_RST),
                          16'(SHAKE_HOLD_RST), 16'(TILT_SETTLE_RST),
                          16'(TILT_DEBOUNCE_RST), 16'(LIFT_THRESHOLD_RST));
        3: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        default: apply_settings(16'($urandom_range(0, 600)),
                                {8'($urandom), 8'($urandom_range(0, 12))},
                                16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1200)),
                                {8'($urandom), 8'($urandom_range(0, 30))},
                                16'($urandom));
      endcase
      // run one phase back to back on both sides
      idle_on  = (p != 1);
      stall_on = (p != 1);
      for (int n = 0; n < PHASE_BEATS; n++) send_tick(next_random_tick(), 1'b0, '0);
    end

    drain_results();
    repeat (RESULT_LATENCY + 4) @(posedge clk);
    $display("Run covered %0d ticks and %0d result beats over %0d register settings,",
             beats_sent, results_checked, PHASES + 2);
    $display("with %0d shake onsets and %0d orientation commits; %0d mismatches.",
             shake_onsets, tilt_commits, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[shake_and_tilt_detector] OK");
    end else begin
      $display("%0d expected result beats never arrived", pending_results.size());
      $display("[shake_and_tilt_detector] ERROR");
    end
    $finish;
  end

endmodule
